>>> rtl/core/gcm_ghash_tag_top_macros.svh
// ----------------------------------------------------------------------------
// GCM GHASH tag engine - assertion macros
// Shared concurrent assertion shorthands for the tag engine RTL.
// ----------------------------------------------------------------------------
`ifndef GCM_GHASH_TAG_TOP_MACROS_SVH
`define GCM_GHASH_TAG_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GGT_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ggt assertion failed");

// Next-cycle implication, disabled during reset.
`define GGT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ggt assertion failed");

`endif

>>> rtl/core/ggt_pkg.sv
// ----------------------------------------------------------------------------
// GCM GHASH tag engine - package
// Types, codes and the GF(2^128) multiply in GCM bit order.
// ----------------------------------------------------------------------------
package ggt_pkg;

   localparam int BLOCK_BYTES = 16;
   localparam int BLOCK_BITS  = 128;
   localparam int HALF_BITS   = 64;
   localparam int COUNT_BITS  = 61;
   localparam int NBYTES_BITS = 5;

   typedef logic [1:0]             opcode_type;
   typedef logic [BLOCK_BITS-1:0]  block_type;
   typedef logic [HALF_BITS-1:0]   half_type;
   typedef logic [COUNT_BITS-1:0]  count_type;
   typedef logic [NBYTES_BITS-1:0] nbytes_type;
   typedef logic [1:0]             reg_index_type;

   localparam opcode_type OP_START  = 2'd0;
   localparam opcode_type OP_AAD    = 2'd1;
   localparam opcode_type OP_TEXT   = 2'd2;
   localparam opcode_type OP_FINISH = 2'd3;

   localparam reg_index_type REG_HASH_KEY_HIGH = 2'd0;
   localparam reg_index_type REG_HASH_KEY_LOW  = 2'd1;
   localparam reg_index_type REG_TAG_MASK_HIGH = 2'd2;
   localparam reg_index_type REG_TAG_MASK_LOW  = 2'd3;

   localparam nbytes_type NBYTES_FULL = nbytes_type'(BLOCK_BYTES);

   // Clamp a byte count to a full block.
   function automatic nbytes_type clamp_nbytes(input nbytes_type n);
      return (n > NBYTES_FULL) ? NBYTES_FULL : n;
   endfunction

   // Zero the bytes at and past n; byte 0 sits in the top bits.
   function automatic block_type mask_block(input block_type data, input nbytes_type n);
      block_type res;
      res = '0;
      for (int k = 0; k < BLOCK_BYTES; k++) begin
         if (nbytes_type'(k) < n) begin
            res[BLOCK_BITS-1-8*k -: 8] = data[BLOCK_BITS-1-8*k -: 8];
         end
      end
      return res;
   endfunction

   // Bit reversal: GCM bit i (MSB first) becomes coefficient of x^i.
   function automatic block_type bit_reverse(input block_type v);
      block_type r;
      for (int i = 0; i < BLOCK_BITS; i++) begin
         r[i] = v[BLOCK_BITS-1-i];
      end
      return r;
   endfunction

   // Carry-less product, then reduction by x^128 + x^7 + x^2 + x + 1.
   function automatic block_type gf_mul(input block_type a, input block_type b);
      block_type                   ar;
      block_type                   br;
      logic [2*BLOCK_BITS-2:0]     prod;
      logic [BLOCK_BITS-2:0]       hi;
      logic [BLOCK_BITS+5:0]       fold;
      logic [5:0]                  spill;
      block_type                   low;
      ar   = bit_reverse(a);
      br   = bit_reverse(b);
      prod = '0;
      for (int i = 0; i < BLOCK_BITS; i++) begin
         if (ar[i]) begin
            prod = prod ^ ({(BLOCK_BITS-1)'(0), br} << i);
         end
      end
      hi    = prod[2*BLOCK_BITS-2:BLOCK_BITS];
      fold  = {7'b0, hi} ^ ({7'b0, hi} << 1) ^ ({7'b0, hi} << 2) ^ ({7'b0, hi} << 7);
      spill = fold[BLOCK_BITS+5:BLOCK_BITS];
      low   = prod[BLOCK_BITS-1:0] ^ fold[BLOCK_BITS-1:0];
      low   = low ^ {122'b0, spill} ^ {121'b0, spill, 1'b0}
                  ^ {120'b0, spill, 2'b0} ^ {115'b0, spill, 7'b0};
      return bit_reverse(low);
   endfunction

   // Byte count plus block bytes, saturating at the all-ones count.
   function automatic count_type sat_add(input count_type c, input nbytes_type n);
      logic [COUNT_BITS:0] s;
      s = {1'b0, c} + {(COUNT_BITS+1-NBYTES_BITS)'(0), n};
      return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
   endfunction

endpackage

>>> rtl/core/gcm_ghash_tag_top.sv
// ----------------------------------------------------------------------------
// GCM GHASH tag engine - top level
// Folds AAD and ciphertext blocks into GHASH and emits the masked GCM tag.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* channel (valid/ready): one beat per block or command. opcode picks
//    start (clear), AAD block, ciphertext block or finish. Block bytes past
//    req_valid_bytes (clamped to 16) count as zero; a block with no valid
//    bytes is taken and dropped without touching state.
//  - rsp_* channel (valid/ready): one beat per finish, carrying the tag
//    GHASH(H, A, C) ^ E(K,Y0) as two big-endian halves.
//  - csr_* port: plain write, index 0..3 = H high/low, E(K,Y0) high/low.
//    Write only while the engine is idle.
// Timing:
//  - One beat per cycle sustained unless a finish is held back: a single
//    GF(2^128) multiply sits between the input register and the accumulator,
//    and a new beat is taken while the previous one is being folded in.
//  - Finish result is registered: rsp_valid rises from the result register once the finish fires.
//  - A finish waits in the input register while an unread tag is held and
//    rsp_ready is low; req_ready drops only then. Other beats keep flowing.
// Reset clears the accumulator, both byte counts, the key and mask registers
// and both channel valid flags.
// ----------------------------------------------------------------------------
module gcm_ghash_tag_top (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  ggt_pkg::opcode_type    req_opcode,
   input  ggt_pkg::half_type      req_data_high,
   input  ggt_pkg::half_type      req_data_low,
   input  ggt_pkg::nbytes_type    req_valid_bytes,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output ggt_pkg::half_type      rsp_tag_high,
   output ggt_pkg::half_type      rsp_tag_low,
   input  logic                   csr_write_en,
   input  ggt_pkg::reg_index_type csr_index,
   input  ggt_pkg::half_type      csr_write_data
);
   import ggt_pkg::*;

   // config registers
   half_type   hash_key_high_ff, hash_key_low_ff;
   half_type   tag_mask_high_ff, tag_mask_low_ff;

   // input stage
   logic       in_valid_ff,  in_valid_in;
   opcode_type in_opcode_ff;
   block_type  in_block_ff;
   nbytes_type in_nbytes_ff;

   // hash state
   block_type  acc_ff,        acc_in;
   count_type  aad_count_ff,  aad_count_in;
   count_type  text_count_ff, text_count_in;

   // result stage
   logic       rsp_valid_ff, rsp_valid_in;
   block_type  rsp_tag_ff,   rsp_tag_in;

   logic       out_free;
   logic       proc_fire;
   logic       in_take;
   block_type  len_block;
   block_type  gf_in;
   block_type  gf_out;

   // assertion terms
   logic       fin_fire;
   logic       clr_fire;
   logic       empty_fire;
   logic       state_clear;

   // Finish needs the result slot; everything else always drains.
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proc_fire = in_valid_ff && ((in_opcode_ff != OP_FINISH) || out_free);
   assign req_ready = !in_valid_ff || proc_fire;
   assign in_take   = req_valid && req_ready;

   assign in_valid_in = in_take || (in_valid_ff && !proc_fire);

   // len(A) || len(C) in bits
   assign len_block = {aad_count_ff, 3'b000, text_count_ff, 3'b000};

   assign gf_in  = acc_ff ^ ((in_opcode_ff == OP_FINISH) ? len_block : in_block_ff);
   assign gf_out = gf_mul(gf_in, {hash_key_high_ff, hash_key_low_ff});

   always_comb begin
      acc_in        = acc_ff;
      aad_count_in  = aad_count_ff;
      text_count_in = text_count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_tag_in    = rsp_tag_ff;
      if (proc_fire) begin
         unique case (in_opcode_ff)
            OP_START: begin
               acc_in        = '0;
               aad_count_in  = '0;
               text_count_in = '0;
            end
            OP_AAD: begin
               if (in_nbytes_ff != '0) begin
                  acc_in       = gf_out;
                  aad_count_in = sat_add(aad_count_ff, in_nbytes_ff);
               end
            end
            OP_TEXT: begin
               if (in_nbytes_ff != '0) begin
                  acc_in        = gf_out;
                  text_count_in = sat_add(text_count_ff, in_nbytes_ff);
               end
            end
            OP_FINISH: begin
               rsp_valid_in  = 1'b1;
               rsp_tag_in    = gf_out ^ {tag_mask_high_ff, tag_mask_low_ff};
               acc_in        = '0;
               aad_count_in  = '0;
               text_count_in = '0;
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_key_high_ff <= '0;
         hash_key_low_ff  <= '0;
         tag_mask_high_ff <= '0;
         tag_mask_low_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_HASH_KEY_HIGH: hash_key_high_ff <= csr_write_data;
            REG_HASH_KEY_LOW:  hash_key_low_ff  <= csr_write_data;
            REG_TAG_MASK_HIGH: tag_mask_high_ff <= csr_write_data;
            REG_TAG_MASK_LOW:  tag_mask_low_ff  <= csr_write_data;
            default:           hash_key_high_ff <= hash_key_high_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         acc_ff        <= '0;
         aad_count_ff  <= '0;
         text_count_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         acc_ff        <= acc_in;
         aad_count_ff  <= aad_count_in;
         text_count_ff <= text_count_in;
      end
   end

   // payload registers, masked on the way in
   always_ff @(posedge clock) begin
      rsp_tag_ff <= rsp_tag_in;
      if (in_take) begin
         in_opcode_ff <= req_opcode;
         in_nbytes_ff <= clamp_nbytes(req_valid_bytes);
         in_block_ff  <= mask_block({req_data_high, req_data_low},
                                    clamp_nbytes(req_valid_bytes));
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_tag_high = rsp_tag_ff[BLOCK_BITS-1:HALF_BITS];
   assign rsp_tag_low  = rsp_tag_ff[HALF_BITS-1:0];

   assign fin_fire    = proc_fire && (in_opcode_ff == OP_FINISH);
   assign clr_fire    = proc_fire && ((in_opcode_ff == OP_START) || (in_opcode_ff == OP_FINISH));
   assign empty_fire  = proc_fire && ((in_opcode_ff == OP_AAD) || (in_opcode_ff == OP_TEXT))
                        && (in_nbytes_ff == '0);
   assign state_clear = (acc_ff == '0) && (aad_count_ff == '0) && (text_count_ff == '0);

   `include "gcm_ghash_tag_top_macros.svh"

   // a finish that fires always leaves a tag in the result register
   `GGT_ASSERT_NEXT(a_finish_gives_tag, clock, reset, fin_fire, rsp_valid_ff)

   // start and finish leave the hash state cleared
   `GGT_ASSERT_NEXT(a_clear_state, clock, reset, clr_fire, state_clear)

   // an empty block leaves the accumulator alone
   `GGT_ASSERT_NEXT(a_empty_block_idle, clock, reset, empty_fire, $stable(acc_ff))

   // the clamp keeps the stored byte count within one block
   `GGT_ASSERT_IMPL(a_nbytes_clamped, clock, reset, in_valid_ff, in_nbytes_ff <= NBYTES_FULL)

endmodule
